[sv/rpf_pkg.sv]
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the register packet framer
// Item and result structs, command codes, CRC helpers and address word
// builder.
// ----------------------------------------------------------------------------
package rpf_pkg;

    localparam int          MAX_PACKET_WORDS = 1024;
    localparam logic [10:0] MAX_WORDS_LIM    = 11'(MAX_PACKET_WORDS);
    localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PAIR  = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;

    localparam logic [2:0] REG_START_WORD  = 3'd0;
    localparam logic [2:0] REG_HEADER_WORD = 3'd1;
    localparam logic [2:0] REG_END_WORD    = 3'd2;
    localparam logic [2:0] REG_FW_VERSION  = 3'd3;
    localparam logic [2:0] REG_CRC_SEED    = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [8:0]  pair_count;
        logic [31:0] reg_value;
        logic [23:0] reg_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        error;
    } out_item_t;

    typedef struct packed {
        logic [31:0] start_word;
        logic [31:0] header_word;
        logic [31:0] end_word;
        logic [31:0] firmware_version;
        logic [31:0] crc_seed;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        close;
        logic [31:0] w0;
        logic [31:0] w1;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

    typedef logic [31:0][31:0] crc_mat_t;

    // Row i holds x^(32+i) mod P
    function automatic crc_mat_t crc_mat_build();
        crc_mat_t    m;
        logic [31:0] c;
        m = '0;
        for (int i = 0; i < 32; i++)
        begin
            c = 32'd1 << i;
            for (int b = 0; b < 32; b++)
            begin
                c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam crc_mat_t CRC_MAT = crc_mat_build();

    // 32 zero-bit shifts of the CRC register
    function automatic logic [31:0] crc_shift32(logic [31:0] c);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (c[i])
            begin
                r = r ^ CRC_MAT[i];
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] byte_parities(logic [31:0] w);
        logic [3:0] p;
        for (int i = 0; i < 4; i++)
        begin
            p[i] = ^w[8*i +: 8];
        end
        return p;
    endfunction

    function automatic logic [31:0] addr_word(logic [31:0] value, logic [23:0] addr);
        logic [3:0] pa;
        logic [3:0] pv;
        pa = byte_parities({8'd0, addr});
        pv = byte_parities(value);
        return {pa, pv, addr};
    endfunction

endpackage

[sv/rpf_cfg.sv]
// ----------------------------------------------------------------------------
// rpf_cfg: configuration register file
// APB-style write and read of the five packet framing registers.
// ----------------------------------------------------------------------------
module rpf_cfg
    import rpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_START_WORD:  cfg_reg.start_word       <= pwdata;
                REG_HEADER_WORD: cfg_reg.header_word      <= pwdata;
                REG_END_WORD:    cfg_reg.end_word         <= pwdata;
                REG_FW_VERSION:  cfg_reg.firmware_version <= pwdata;
                REG_CRC_SEED:    cfg_reg.crc_seed         <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_START_WORD:  prdata = cfg_reg.start_word;
            REG_HEADER_WORD: prdata = cfg_reg.header_word;
            REG_END_WORD:    prdata = cfg_reg.end_word;
            REG_FW_VERSION:  prdata = cfg_reg.firmware_version;
            REG_CRC_SEED:    prdata = cfg_reg.crc_seed;
            default:         prdata = '0;
        endcase
    end

endmodule

[sv/rpf_front.sv]
// ----------------------------------------------------------------------------
// rpf_front: item classifier and command queue
// Track packet state per item and queue start, pair and error commands.
// ----------------------------------------------------------------------------
module rpf_front
    import rpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    output cmd_link_t head,
    input  logic      cmd_pop
);

    cmd_t       cmd_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    logic [8:0] pairs_reg;
    logic [8:0] pairs_next;
    logic       in_packet_reg;
    logic       in_packet_next;
    logic       rejecting_reg;
    logic       rejecting_next;

    logic       accept;
    logic       do_push;
    cmd_t       new_cmd;
    logic [10:0] words_needed;
    logic [8:0]  pairs_dec;

    assign full   = (count_reg == 2'd2);
    assign accept = push && !full;

    assign words_needed = {1'b0, item.pair_count, 1'b0} + 11'd6;
    assign pairs_dec    = pairs_reg - 9'd1;

    always_comb
    begin
        do_push        = 1'b0;
        new_cmd        = '0;
        pairs_next     = pairs_reg;
        in_packet_next = in_packet_reg;
        rejecting_next = rejecting_reg;
        if (!item.mode)
        begin
            pairs_next = item.pair_count;
            do_push    = 1'b1;
            if (words_needed > MAX_WORDS_LIM)
            begin
                new_cmd.kind   = CMD_ERROR;
                in_packet_next = 1'b0;
                rejecting_next = (item.pair_count != 9'd0);
            end
            else
            begin
                new_cmd.kind   = CMD_START;
                new_cmd.close  = (item.pair_count == 9'd0);
                new_cmd.w0     = {22'd0, item.pair_count, 1'b0} + 32'd5;
                in_packet_next = (item.pair_count != 9'd0);
                rejecting_next = 1'b0;
            end
        end
        else if (rejecting_reg)
        begin
            pairs_next     = pairs_dec;
            rejecting_next = (pairs_dec != 9'd0);
        end
        else if (in_packet_reg)
        begin
            do_push        = 1'b1;
            new_cmd.kind   = CMD_PAIR;
            new_cmd.close  = (pairs_dec == 9'd0);
            new_cmd.w0     = item.reg_value;
            new_cmd.w1     = addr_word(item.reg_value, item.reg_address);
            pairs_next     = pairs_dec;
            in_packet_next = (pairs_dec != 9'd0);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && do_push)
        begin
            count_next = count_next + 2'd1;
        end
        if (cmd_pop)
        begin
            count_next = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= '0;
            pairs_reg     <= '0;
            in_packet_reg <= 1'b0;
            rejecting_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (accept)
            begin
                pairs_reg     <= pairs_next;
                in_packet_reg <= in_packet_next;
                rejecting_reg <= rejecting_next;
                if (do_push)
                begin
                    wr_ptr_reg <= !wr_ptr_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_push)
        begin
            cmd_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = cmd_mem_reg[rd_ptr_reg];

endmodule

[sv/rpf_back.sv]
// ----------------------------------------------------------------------------
// rpf_back: packet word sequencer and result queue
// Expand each command into packet words, run the CRC and queue results.
// ----------------------------------------------------------------------------
module rpf_back
    import rpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_link_t head,
    output logic      cmd_pop,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    logic [2:0]  step_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    out_item_t   out_mem_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;

    logic        emit;
    logic        step_done;
    logic        out_pop;
    out_item_t   emit_item;
    logic [31:0] crc_closed;

    assign emit       = head.valid && (count_reg != 3'd4);
    assign out_pop    = pop && !empty;
    assign crc_closed = crc_shift32(crc_reg);

    always_comb
    begin
        emit_item = '0;
        crc_next  = crc_reg;
        step_done = 1'b0;
        unique case (head.cmd.kind)
            CMD_START:
            begin
                unique case (step_reg)
                    3'd0: emit_item.word = cfg.start_word;
                    3'd1: emit_item.word = head.cmd.w0;
                    3'd2:
                    begin
                        emit_item.word = cfg.firmware_version;
                        crc_next       = crc_shift32(cfg.crc_seed) ^ cfg.firmware_version;
                    end
                    3'd3:
                    begin
                        emit_item.word = cfg.header_word;
                        crc_next       = crc_closed ^ cfg.header_word;
                        step_done      = !head.cmd.close;
                    end
                    3'd4: emit_item.word = cfg.end_word;
                    default:
                    begin
                        emit_item.word = crc_closed;
                        emit_item.last = 1'b1;
                        step_done      = 1'b1;
                    end
                endcase
            end
            CMD_PAIR:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        emit_item.word = head.cmd.w0;
                        crc_next       = crc_closed ^ head.cmd.w0;
                    end
                    3'd1:
                    begin
                        emit_item.word = head.cmd.w1;
                        crc_next       = crc_closed ^ head.cmd.w1;
                        step_done      = !head.cmd.close;
                    end
                    3'd2: emit_item.word = cfg.end_word;
                    default:
                    begin
                        emit_item.word = crc_closed;
                        emit_item.last = 1'b1;
                        step_done      = 1'b1;
                    end
                endcase
            end
            default:
            begin
                emit_item.last  = 1'b1;
                emit_item.error = 1'b1;
                step_done       = 1'b1;
            end
        endcase
    end

    assign cmd_pop = emit && step_done;

    always_comb
    begin
        count_next = count_reg;
        if (emit)
        begin
            count_next = count_next + 3'd1;
        end
        if (out_pop)
        begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            crc_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (emit)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
                crc_reg    <= crc_next;
                step_reg   <= step_done ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_mem_reg[wr_ptr_reg] <= emit_item;
        end
    end

    assign empty  = (count_reg == 3'd0);
    assign result = out_mem_reg[rd_ptr_reg];

endmodule

[sv/register_packet_framer_crc32.sv]
// ----------------------------------------------------------------------------
// Path: the first result word goes through the command queue and then the result queue.
// Throughput: one result word per cycle from the word sequencer in rpf_back
//   while its result queue is not full; a pair item gives 2 words (4 when it
//   closes the packet), a start item 4 words (6 when it closes).
// Reset: rst_n clears packet state, queues and all configuration registers.
// ----------------------------------------------------------------------------
// register_packet_framer_crc32: register-write packet builder with CRC-32
// Front classifies items into commands, back expands them into packet words.
// ----------------------------------------------------------------------------
module register_packet_framer_crc32
    import rpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    item,
    output logic        full,
    output out_item_t   result,
    output logic        empty,
    input  logic        pop,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg;
    cmd_link_t head;
    logic      cmd_pop;

    rpf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .head    (head),
        .cmd_pop (cmd_pop)
    );

    rpf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .cmd_pop (cmd_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

[sv/rpf_checker.sv]
// ----------------------------------------------------------------------------
// rpf_checker: port-level checks of the packet framer
// Result field rules, result hold under stall and config port readiness.
// ----------------------------------------------------------------------------
module rpf_checker
    import rpf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input out_item_t result,
    input logic      empty,
    input logic      pop,
    input logic      pready
);

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.error) |-> result.last)
        else $error("error result without last");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.error) |-> (result.word == 32'd0))
        else $error("error result with nonzero word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind register_packet_framer_crc32 rpf_checker u_rpf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .empty  (empty),
    .pop    (pop),
    .pready (pready)
);

[bench/register_packet_framer_crc32_tb.sv]
// ----------------------------------------------------------------------------
// register_packet_framer_crc32_tb: self-checking bench for the packet framer
// Drives start and pair items through the push/full queue port, programs the
// marker, version and seed registers over APB between phases, and checks each
// popped packet word against typed words or a cycle-free model of framer and CRC-32.
// A directed table covers empty, longest and oversized packets, restarts and
// stray pairs; random packets with random idling on both sides follow.
// ----------------------------------------------------------------------------
module register_packet_framer_crc32_tb;
    import rpf_pkg::*;

    localparam logic        MODE_START      = 1'b0;
    localparam logic        MODE_PAIR       = 1'b1;
    localparam logic [31:0] POLY            = 32'h04C1_1DB7;
    localparam logic [3:0]  BY_MODEL        = 4'd15;
    localparam int          SETTLE_CYCLES   = 32;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          ITEMS_PER_PHASE = 85;
    localparam int          MAX_REPORTS     = 40;
    localparam int          N_DIRECTED      = 19;

    typedef struct packed {
        in_item_t        stim;
        logic [3:0]      n_typed;
        out_item_t [0:5] words;
    } stim_row_t;

    localparam out_item_t       W_ZERO     = {32'd0, 1'b0, 1'b0};
    localparam out_item_t       W_LEN5     = {32'd5, 1'b0, 1'b0};
    localparam out_item_t       W_LEN7     = {32'd7, 1'b0, 1'b0};
    localparam out_item_t       W_LEN1023  = {32'd1023, 1'b0, 1'b0};
    localparam out_item_t       W_CRC_ZERO = {32'd0, 1'b1, 1'b0};
    localparam out_item_t       W_REJECT   = {32'd0, 1'b1, 1'b1};
    localparam out_item_t [0:5] NO_WORDS   = '0;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // empty packet with registers at reset
        {{MODE_START, 9'd0, 32'h0000_0000, 24'h00_0000}, 4'd6,
         {W_ZERO, W_LEN5, W_ZERO, W_ZERO, W_ZERO, W_CRC_ZERO}},
        // stray pair outside a packet
        {{MODE_PAIR, 9'h1FF, 32'hFFFF_FFFF, 24'hFF_FFFF}, 4'd0, NO_WORDS},
        // oversized, largest count, then a dropped pair
        {{MODE_START, 9'd511, 32'hFFFF_FFFF, 24'hFF_FFFF}, 4'd1, {W_REJECT, {5{W_ZERO}}}},
        {{MODE_PAIR, 9'd0, 32'h1234_5678, 24'hAB_CDEF}, 4'd0, NO_WORDS},
        // restart inside a rejection, smallest oversized count
        {{MODE_START, 9'd510, 32'h0000_0000, 24'h00_0000}, 4'd1, {W_REJECT, {5{W_ZERO}}}},
        {{MODE_PAIR, 9'h1FF, 32'h8000_0000, 24'h80_0000}, 4'd0, NO_WORDS},
        // longest legal packet, abandoned by the next start
        {{MODE_START, 9'd509, 32'hFFFF_FFFF, 24'hFF_FFFF}, 4'd4,
         {W_ZERO, W_LEN1023, W_ZERO, W_ZERO, {2{W_ZERO}}}},
        {{MODE_PAIR, 9'd0, 32'hFFFF_FFFF, 24'hFF_FFFF}, BY_MODEL, NO_WORDS},
        {{MODE_START, 9'd1, 32'h0000_0000, 24'h00_0000}, 4'd4,
         {W_ZERO, W_LEN7, W_ZERO, W_ZERO, {2{W_ZERO}}}},
        {{MODE_PAIR, 9'h1FF, 32'h0000_0000, 24'h00_0000}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'h8000_0000, 24'h80_0000}, 4'd0, NO_WORDS},
        {{MODE_START, 9'd2, 32'h0000_0000, 24'h00_0000}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'h8000_0000, 24'h00_0001}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'h0000_0001, 24'h80_0000}, BY_MODEL, NO_WORDS},
        {{MODE_START, 9'd3, 32'hFFFF_FFFF, 24'hFF_FFFF}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'h0F0F_0F0F, 24'h0F_0F0F}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'h0102_0408, 24'hF0_F0F0}, BY_MODEL, NO_WORDS},
        {{MODE_PAIR, 9'd0, 32'hFFFF_FFFF, 24'h00_0000}, BY_MODEL, NO_WORDS},
        {{MODE_START, 9'd0, 32'h0000_0000, 24'h00_0000}, BY_MODEL, NO_WORDS}
    };

    logic        clk;
    logic        rst_n;
    logic        push;
    in_item_t    item;
    logic        full;
    out_item_t   result;
    logic        empty;
    logic        pop;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cfg_t        shadow;
    logic [31:0] crc_acc;
    logic [8:0]  pairs_left;
    logic        in_pkt;
    logic        dropping;
    out_item_t   pkt_words[$];
    out_item_t   words_due[$];
    int          fails;
    int          framed_items;
    bit          hold_req;
    bit          tx_steady;

    register_packet_framer_crc32 u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [31:0] w);
        logic top;
        for (int b = 31; b >= 0; b--)
        begin
            top = crc[31];
            crc = {crc[30:0], w[b]};
            if (top)
            begin
                crc = crc ^ POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [3:0] byte_par(logic [31:0] w);
        logic [31:0] x;
        x = w ^ (w >> 4);
        x = x ^ (x >> 2);
        x = x ^ (x >> 1);
        return {x[24], x[16], x[8], x[0]};
    endfunction

    function automatic out_item_t mk(logic [31:0] w, logic last, logic err);
        return {w, last, err};
    endfunction

    function automatic void close_frame();
        pkt_words.push_back(mk(shadow.end_word, 1'b0, 1'b0));
        crc_acc = crc_feed(crc_acc, 32'd0);
        pkt_words.push_back(mk(crc_acc, 1'b1, 1'b0));
        in_pkt = 1'b0;
    endfunction

    // Returns 0 when the item is dropped or ignored
    function automatic bit frame_item(in_item_t it);
        logic [31:0] aw;
        pkt_words.delete();
        if (it.mode == MODE_START)
        begin
            in_pkt     = 1'b0;
            dropping   = 1'b0;
            pairs_left = it.pair_count;
            if (2 * int'(it.pair_count) + 6 > MAX_PACKET_WORDS)
            begin
                pkt_words.push_back(mk(32'd0, 1'b1, 1'b1));
                dropping = (it.pair_count != 9'd0);
                return 1'b1;
            end
            pkt_words.push_back(mk(shadow.start_word, 1'b0, 1'b0));
            pkt_words.push_back(mk(32'(2 * int'(it.pair_count) + 5), 1'b0, 1'b0));
            pkt_words.push_back(mk(shadow.firmware_version, 1'b0, 1'b0));
            pkt_words.push_back(mk(shadow.header_word, 1'b0, 1'b0));
            crc_acc = crc_feed(crc_feed(shadow.crc_seed, shadow.firmware_version),
                               shadow.header_word);
            in_pkt  = 1'b1;
            if (it.pair_count == 9'd0)
            begin
                close_frame();
            end
            return 1'b1;
        end
        if (dropping)
        begin
            pairs_left = pairs_left - 9'd1;
            dropping   = (pairs_left != 9'd0);
            return 1'b0;
        end
        if (!in_pkt)
        begin
            return 1'b0;
        end
        aw = {byte_par({8'd0, it.reg_address}), byte_par(it.reg_value), it.reg_address};
        pkt_words.push_back(mk(it.reg_value, 1'b0, 1'b0));
        pkt_words.push_back(mk(aw, 1'b0, 1'b0));
        crc_acc    = crc_feed(crc_feed(crc_acc, it.reg_value), aw);
        pairs_left = pairs_left - 9'd1;
        if (pairs_left == 9'd0)
        begin
            close_frame();
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_item(logic mode, logic [8:0] count);
        in_item_t    it;
        logic [31:0] a;
        a              = rand_word();
        it.mode        = mode;
        it.pair_count  = count;
        it.reg_value   = rand_word();
        it.reg_address = a[23:0];
        return it;
    endfunction

    task automatic send_item(in_item_t it, logic [3:0] n_typed, out_item_t [0:5] typed);
        int gap;
        gap = pick_gap(tx_steady);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        if (frame_item(it))
        begin
            framed_items++;
        end
        if (n_typed == BY_MODEL)
        begin
            foreach (pkt_words[i])
            begin
                words_due.push_back(pkt_words[i]);
            end
        end
        else
        begin
            for (int i = 0; i < n_typed; i++)
            begin
                words_due.push_back(typed[i]);
            end
        end
    endtask

    task automatic send_start(int count);
        send_item(rand_item(MODE_START, 9'(count)), BY_MODEL, NO_WORDS);
    endtask

    task automatic send_pairs(int n);
        repeat (n)
        begin
            send_item(rand_item(MODE_PAIR, 9'($urandom)), BY_MODEL, NO_WORDS);
        end
    endtask

    // Drop push, drain every expected word, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_START_WORD:  shadow.start_word       = val;
            REG_HEADER_WORD: shadow.header_word      = val;
            REG_END_WORD:    shadow.end_word         = val;
            REG_FW_VERSION:  shadow.firmware_version = val;
            REG_CRC_SEED:    shadow.crc_seed         = val;
            default:         ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_regs(logic [31:0] sw, logic [31:0] hw, logic [31:0] ew,
                             logic [31:0] fv, logic [31:0] seed);
        settle();
        reg_write(REG_START_WORD, sw);
        reg_write(REG_HEADER_WORD, hw);
        reg_write(REG_END_WORD, ew);
        reg_write(REG_FW_VERSION, fv);
        reg_write(REG_CRC_SEED, seed);
    endtask

    task automatic random_packet();
        int r;
        int n;
        r         = $urandom_range(0, 99);
        tx_steady = ($urandom_range(0, 7) == 0);
        if (r < 70)
        begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            send_start(n);
            send_pairs(n);
        end
        else if (r < 82)
        begin
            n = $urandom_range(2, 8);
            send_start(n);
            send_pairs($urandom_range(1, n - 1));
        end
        else if (r < 92)
        begin
            send_pairs($urandom_range(1, 3));
        end
        else
        begin
            send_start($urandom_range(510, 511));
            send_pairs($urandom_range(0, 4));
        end
        if ($urandom_range(0, 39) == 0)
        begin
            settle();
        end
    endtask

    task automatic random_phase();
        int target;
        target = framed_items + ITEMS_PER_PHASE;
        while (framed_items < target)
        begin
            random_packet();
        end
    endtask

    task automatic check_result();
        out_item_t want;
        if (words_due.size() == 0)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
            begin
                $display("%0t: unexpected transaction word=%h last=%b error=%b",
                         $time, result.word, result.last, result.error);
            end
            return;
        end
        want = words_due.pop_front();
        if (result.word !== want.word)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
            begin
                $display("%0t: word expected %h, actual %h", $time, want.word, result.word);
            end
        end
        if (result.last !== want.last)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
            begin
                $display("%0t: last expected %b, actual %b (word %h)",
                         $time, want.last, result.last, want.word);
            end
        end
        if (result.error !== want.error)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
            begin
                $display("%0t: error expected %b, actual %b (word %h)",
                         $time, want.error, result.error, want.word);
            end
        end
    endtask

    initial
    begin
        int  rx_wait;
        int  rx_span;
        bit  rx_steady;
        bit  held;
        pop       = 1'b0;
        rx_wait   = 0;
        rx_span   = 0;
        rx_steady = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (rx_span == 0)
            begin
                rx_steady = ($urandom_range(0, 5) == 0);
                rx_span   = $urandom_range(20, 120);
            end
            else
            begin
                rx_span--;
            end
            if (rx_wait > 0)
            begin
                pop <= 1'b0;
                rx_wait--;
            end
            else
            begin
                pop <= 1'b1;
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                check_result();
                rx_wait = pick_gap(rx_steady);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        shadow       = '0;
        crc_acc      = '0;
        pairs_left   = '0;
        in_pkt       = 1'b0;
        dropping     = 1'b0;
        fails        = 0;
        framed_items = 0;
        hold_req     = 1'b0;
        tx_steady    = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_item(DIRECTED[i].stim, DIRECTED[i].n_typed, DIRECTED[i].words);
        end

        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase();

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        hold_req = 1'b1;
        random_phase();

        load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase();

        load_regs(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h04C1_1DB7, 32'h8000_0000);
        random_phase();

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase();

        load_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        random_phase();

        settle();
        if (fails == 0 && words_due.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #3_200_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
